/* sv/bei_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bei_pkg
// Shared constants, types and helper functions of the burst error injector.
// ============================================================================
package bei_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TBL_CNT_W   = (TBL_AW + 1 > 9) ? TBL_AW + 1 : 9;
    localparam int IDX_CMP_W   = (TBL_AW + 1 > 8) ? TBL_AW + 1 : 8;

    localparam int RUN_W   = 40;
    localparam int LFSR_W  = 16;
    localparam int MEAS_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int REM_CNT_W = 5;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [8:0]        BYTE_MOD  = 9'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYPASS      = 3'd0,
        CFG_MODE        = 3'd1,
        CFG_GAP_BYTES   = 3'd2,
        CFG_MEAN_BURST  = 3'd3,
        CFG_AMP_BURST   = 3'd4,
        CFG_TABLE_COUNT = 3'd5,
        CFG_SEED        = 3'd6
    } cfg_idx_t;

    typedef logic [TBL_AW-1:0] tbl_addr_t;

    typedef struct packed {
        logic [MEAS_W-1:0] gap_bits;
        logic [MEAS_W-1:0] burst_bits;
    } tbl_entry_t;

    typedef struct packed {
        logic accept;
        logic table_wr;
        logic emit;
        logic div_start;
        logic tbl_read;
        logic load_run;
    } bei_cmd_t;

    typedef struct packed {
        logic bypass;
        logic mode;
        logic rem_zero;
        logic in_burst;
        logic amp_zero;
        logic out_free;
        logic div_done;
    } bei_status_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        r = {1'b0, v[LFSR_W-1:1]};
        if (v[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    // Since 256 is 1 modulo 255, the high and low bytes are folded twice.
    function automatic logic [7:0] mod255(input logic [LFSR_W-1:0] v);
        logic [8:0] s;
        logic [8:0] t;
        s = {1'b0, v[15:8]} + {1'b0, v[7:0]};
        t = {8'd0, s[8]} + {1'b0, s[7:0]};
        return (t == BYTE_MOD) ? 8'd0 : t[7:0];
    endfunction

endpackage

/* sv/burst_error_injector.sv */
`timescale 1ns / 1ps
// ============================================================================
// burst_error_injector
// Burst error injector for a byte stream with statistic or measured run
// lengths.
// ============================================================================
// A data byte is registered on acceptance and moves on to the output register
// once the output is free; a table write request goes to the table memory on
// acceptance. At a run boundary the new length is loaded first: directly for
// a clean run or fixed error run in statistic mode, after a registered table
// memory read for a table lookup, and after the bit-serial remainder unit,
// one bit per cycle, for a statistic error run with a nonzero spread.
// ============================================================================
module burst_error_injector (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,  // data_byte, table_index, gap_bits, burst_bits
    input  logic                           s_tuser,  // kind
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // out_byte
    output logic                           m_tuser,  // corrupted
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [bei_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bei_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bei_pkg::*;

    bei_cmd_t    cmd;
    bei_status_t status;

    bei_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bei_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

/* sv/bei_rem_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// bei_rem_unit
// Restoring remainder unit for a sixteen-bit dividend: one dividend bit per cycle.
// ============================================================================
module bei_rem_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [bei_pkg::LFSR_W-1:0] dividend,
    input  logic [bei_pkg::LFSR_W-1:0] divisor,
    output logic [bei_pkg::LFSR_W-1:0] remainder,
    output logic                       done
);
    import bei_pkg::*;

    logic [LFSR_W-1:0]    rem_reg, rem_next;
    logic [LFSR_W-1:0]    dvd_reg, dvd_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [LFSR_W:0]      trial;

    always_comb begin
        trial     = {rem_reg, dvd_reg[LFSR_W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = REM_CNT_W'(LFSR_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = LFSR_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[LFSR_W-1:0];
            end
            dvd_next = {dvd_reg[LFSR_W-2:0], 1'b0};
            cnt_next = cnt_reg - REM_CNT_W'(1);
            if (cnt_reg == REM_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign remainder = rem_reg;
    assign done      = !busy_reg;

endmodule

/* sv/bei_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// bei_datapath
// Configuration registers, run countdown, LFSR, measurement table and
// output register of the burst error injector.
// ============================================================================
module bei_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bei_pkg::bei_cmd_t              cmd,
    output bei_pkg::bei_status_t           status,
    input  logic [63:0]                    s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [bei_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bei_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bei_pkg::*;

    logic                 bypass_reg, bypass_next;
    logic                 mode_reg, mode_next;
    logic [RUN_W-1:0]     gap_bytes_reg, gap_bytes_next;
    logic [15:0]          mean_reg, mean_next;
    logic [15:0]          amp_reg, amp_next;
    logic [8:0]           tcount_reg, tcount_next;
    logic [LFSR_W-1:0]    lfsr_reg, lfsr_next;
    logic                 in_burst_reg, in_burst_next;
    logic [RUN_W-1:0]     remaining_reg, remaining_next;
    logic [TBL_AW-1:0]    pos_reg, pos_next;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_data_reg;
    logic                 m_user_reg;
    logic                 m_last_reg;

    tbl_entry_t           tbl_mem [TABLE_DEPTH];
    tbl_entry_t           rd_reg;

    logic [LFSR_W-1:0]    lfsr_adv;
    logic [LFSR_W-1:0]    rem_val;
    logic                 rem_done;
    logic [LFSR_W-1:0]    rterm;
    logic signed [17:0]   stat_sum;
    logic [RUN_W-1:0]     stat_len;
    logic [RUN_W-1:0]     gap_len;
    logic [RUN_W-1:0]     tbl_len;
    logic [RUN_W-1:0]     run_len;
    logic [MEAS_W-1:0]    meas;
    logic [TBL_CNT_W-1:0] pos_inc;
    logic                 corrupt;
    logic [LFSR_W-1:0]    seed_val;
    tbl_addr_t            wr_addr;
    logic                 wr_ok;

    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign corrupt  = !bypass_reg && in_burst_reg;

    bei_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (lfsr_adv),
        .divisor   (amp_reg),
        .remainder (rem_val),
        .done      (rem_done)
    );

    always_comb begin
        rterm    = (amp_reg == '0) ? '0 : rem_val;
        stat_sum = $signed({2'b00, mean_reg}) - $signed({3'b000, amp_reg[15:1]})
                 + $signed({2'b00, rterm});
        stat_len = (stat_sum < 18'sd1) ? RUN_W'(1) : RUN_W'(stat_sum[16:0]);
        gap_len  = (gap_bytes_reg == '0) ? RUN_W'(1) : gap_bytes_reg;
        meas     = in_burst_reg ? rd_reg.gap_bits : rd_reg.burst_bits;
        tbl_len  = RUN_W'({1'b0, meas[MEAS_W-1:3]} + 22'd1);
        if (mode_reg) begin
            run_len = tbl_len;
        end else begin
            run_len = in_burst_reg ? gap_len : stat_len;
        end
        pos_inc  = TBL_CNT_W'(pos_reg) + TBL_CNT_W'(1);
    end

    always_comb begin
        bypass_next    = bypass_reg;
        mode_next      = mode_reg;
        gap_bytes_next = gap_bytes_reg;
        mean_next      = mean_reg;
        amp_next       = amp_reg;
        tcount_next    = tcount_reg;
        lfsr_next      = lfsr_reg;
        in_burst_next  = in_burst_reg;
        remaining_next = remaining_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg;
        seed_val       = cfg_wdata[LFSR_W-1:0];

        if (cmd.div_start) begin
            lfsr_next = lfsr_adv;
        end
        if (cmd.load_run) begin
            in_burst_next  = !in_burst_reg;
            remaining_next = run_len;
            if (mode_reg && !in_burst_reg) begin
                if (pos_inc >= TBL_CNT_W'(tcount_reg)
                        || pos_inc >= TBL_CNT_W'(TABLE_DEPTH)) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_inc[TBL_AW-1:0];
                end
            end
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            if (!bypass_reg) begin
                remaining_next = remaining_reg - RUN_W'(1);
                if (in_burst_reg) begin
                    lfsr_next = lfsr_adv;
                end
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                CFG_BYPASS: begin
                    bypass_next    = cfg_wdata[0];
                    remaining_next = '0;
                end
                CFG_MODE: begin
                    mode_next      = cfg_wdata[0];
                    remaining_next = '0;
                end
                CFG_GAP_BYTES: begin
                    gap_bytes_next = cfg_wdata[RUN_W-1:0];
                    remaining_next = '0;
                end
                CFG_MEAN_BURST: begin
                    mean_next      = cfg_wdata[15:0];
                    remaining_next = '0;
                end
                CFG_AMP_BURST: begin
                    amp_next       = cfg_wdata[15:0];
                    remaining_next = '0;
                end
                CFG_TABLE_COUNT: begin
                    tcount_next    = cfg_wdata[8:0];
                    remaining_next = '0;
                end
                CFG_SEED: begin
                    lfsr_next      = (seed_val == '0) ? LFSR_W'(1) : seed_val;
                    remaining_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            gap_bytes_reg <= RUN_W'(100000000);
            mean_reg      <= 16'd1;
            amp_reg       <= 16'd0;
            tcount_reg    <= 9'd1;
            lfsr_reg      <= LFSR_W'(1);
            in_burst_reg  <= 1'b0;
            remaining_reg <= '0;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            bypass_reg    <= bypass_next;
            mode_reg      <= mode_next;
            gap_bytes_reg <= gap_bytes_next;
            mean_reg      <= mean_next;
            amp_reg       <= amp_next;
            tcount_reg    <= tcount_next;
            lfsr_reg      <= lfsr_next;
            in_burst_reg  <= in_burst_next;
            remaining_reg <= remaining_next;
            pos_reg       <= pos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata[7:0];
            last_reg <= s_tlast;
        end
        if (cmd.emit) begin
            m_data_reg <= corrupt ? mod255(lfsr_adv) : byte_reg;
            m_user_reg <= corrupt;
            m_last_reg <= last_reg;
        end
    end

    assign wr_addr = tbl_addr_t'(s_tdata[15:8]);
    assign wr_ok   = IDX_CMP_W'(s_tdata[15:8]) < IDX_CMP_W'(TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (cmd.table_wr && wr_ok) begin
            tbl_mem[wr_addr] <= '{gap_bits: s_tdata[39:16], burst_bits: s_tdata[63:40]};
        end
        if (cmd.tbl_read) begin
            rd_reg <= tbl_mem[pos_reg];
        end
    end

    assign status = '{
        bypass:   bypass_reg,
        mode:     mode_reg,
        rem_zero: (remaining_reg == '0),
        in_burst: in_burst_reg,
        amp_zero: (amp_reg == '0),
        out_free: (!m_valid_reg || m_tready),
        div_done: rem_done
    };

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* sv/bei_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// bei_ctrl
// Controller of the burst error injector: sequences request intake, run
// changes and result delivery.
// ============================================================================
module bei_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  bei_pkg::bei_status_t status,
    output bei_pkg::bei_cmd_t    cmd
);
    import bei_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_TBL  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept   = 1'b1;
                    cmd.table_wr = s_tuser;
                    if (!s_tuser) begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (status.bypass || !status.rem_zero) begin
                    if (status.out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (status.mode) begin
                    cmd.tbl_read = 1'b1;
                    state_next   = S_TBL;
                end else if (!status.in_burst && !status.amp_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.load_run = 1'b1;
                end
            end
            S_DIV: begin
                if (status.div_done) begin
                    cmd.load_run = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_TBL: begin
                cmd.load_run = 1'b1;
                state_next   = S_EVAL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/bei_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// bei_checker
// Port-level assertions for the burst error injector.
// ============================================================================
module bei_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Result changed while stalled.");

    a_corrupt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata != 8'hFF)
        else $error("Corrupted byte outside the LFSR residue range.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("New request taken while a data byte is in work.");

    a_table_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("Table write request produced a result.");

endmodule

bind burst_error_injector bei_checker u_bei_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
